// ----- rtl/core/nonlinear_slew_filter_macros.svh -----
// Assertion macros for the nonlinear slew filter checker.
// Each macro expects clk and rst in scope.
`ifndef NONLINEAR_SLEW_FILTER_MACROS_SVH
`define NONLINEAR_SLEW_FILTER_MACROS_SVH
// same-cycle implication, disabled in reset
`define NSF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled in reset
`define NSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// next-cycle implication that also watches reset itself
`define NSF_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/core/nsf_pkg.sv -----
// Shared types and constants of the nonlinear slew filter.
// Used by nsf_ctrl, nsf_dp and the top level.
`default_nettype none
package nsf_pkg;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CUT, OP_REGION, OP_DIV, OP_NINIT, OP_NORM,
    OP_SQR, OP_LOGM, OP_POLY, OP_PSHIFT, OP_GAIN, OP_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       first;
    logic [1:0] poly_k;
  } dp_cmd_t;

  typedef struct packed {
    logic norm_busy;
    logic y_zero;
  } dp_stat_t;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_DEPTH = 2'd1;
  localparam logic [1:0] CFG_STEEP = 2'd2;

  localparam logic [15:0] BASE_RESET  = 16'd4096;
  localparam logic [15:0] DEPTH_RESET = 16'd0;
  localparam logic [15:0] STEEP_RESET = 16'd8192;

  localparam logic [4:0] DIV_LAST  = 5'd16;
  localparam logic [4:0] SQR_LAST  = 5'd15;
  localparam logic [4:0] POLY_LAST = 5'd2;

  localparam logic [17:0] POLY_C1    = 18'd45617;
  localparam logic [17:0] POLY_C2    = 18'd14713;
  localparam logic [17:0] POLY_C3    = 18'd5206;
  localparam logic [17:0] ONE_Q16    = 18'd65536;
  localparam logic [17:0] TWO_Q16    = 18'd131072;
  localparam logic [15:0] GAIN_SCALE = 16'd58982;
  localparam logic [16:0] GAIN_FLOOR = 17'd6554;

endpackage
`default_nettype wire

// ----- rtl/core/nonlinear_slew_filter.sv -----
// Top level of the nonlinear slew filter: configuration registers, sequencer
// and datapath. Depends on nsf_pkg, nsf_ctrl and nsf_dp.
//
// channel  dir  handshake             payload
// s_       in   s_tvalid/s_tready     s_tdata: sample_in, cutoff_mod
// m_       out  m_tvalid/m_tready     m_tdata: sample_out
// cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// An item passes from accept through the divider, the normalize shifts, the
// squaring steps and the multiply steps, which share one multiplier. The next
// item is taken once the result is registered. Reset is synchronous; it clears
// the held output and loads the register defaults. A stalled result holds; the
// last step of the next item waits for it to leave.
`default_nettype none
module nonlinear_slew_filter (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [31:0] s_tdata,    // [15:0] sample_in, [31:16] cutoff_mod
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample_out
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [1:0]  cfg_index,
  input  wire [15:0] cfg_data
);
  import nsf_pkg::*;

  logic [15:0] base_cutoff, cutoff_depth, steepness;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  // config writes are always taken; unknown index is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_cutoff  <= BASE_RESET;
      cutoff_depth <= DEPTH_RESET;
      steepness    <= STEEP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BASE:  base_cutoff  <= cfg_data;
        CFG_DEPTH: cutoff_depth <= cfg_data;
        CFG_STEEP: steepness    <= cfg_data;
        default: ;
      endcase
    end
  end

  nsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nsf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample_in    (s_tdata[15:0]),
    .cutoff_mod   (s_tdata[31:16]),
    .base_cutoff  (base_cutoff),
    .cutoff_depth (cutoff_depth),
    .steepness    (steepness),
    .sample_out   (m_tdata)
  );

endmodule
`default_nettype wire

// ----- rtl/core/nsf_ctrl.sv -----
// Sequencer of the nonlinear slew filter: steps the datapath through one item.
// Depends on nsf_pkg.
`default_nettype none
module nsf_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire               m_tready,
  input  nsf_pkg::dp_stat_t stat,
  output nsf_pkg::dp_cmd_t  cmd
);
  import nsf_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_CUT    = 12'b0000_0000_0010,
    S_REGION = 12'b0000_0000_0100,
    S_DIV    = 12'b0000_0000_1000,
    S_NINIT  = 12'b0000_0001_0000,
    S_NORM   = 12'b0000_0010_0000,
    S_SQR    = 12'b0000_0100_0000,
    S_LOGM   = 12'b0000_1000_0000,
    S_POLY   = 12'b0001_0000_0000,
    S_PSHIFT = 12'b0010_0000_0000,
    S_GAIN   = 12'b0100_0000_0000,
    S_STEP   = 12'b1000_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       out_fire;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    out_fire   = 1'b0;
    cmd        = '{op: OP_NONE, first: 1'b0, poly_k: 2'd0};
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CUT;
        end
      end
      S_CUT: begin
        cmd.op     = OP_CUT;
        state_next = S_REGION;
      end
      S_REGION: begin
        cmd.op     = OP_REGION;
        cnt_next   = 5'd0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op    = OP_DIV;
        cmd.first = (cnt == 5'd0);
        cnt_next  = cnt + 5'd1;
        if (cnt == DIV_LAST) state_next = S_NINIT;
      end
      S_NINIT: begin
        cmd.op     = OP_NINIT;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (stat.norm_busy) begin
          cmd.op = OP_NORM;
        end else begin
          cnt_next   = 5'd0;
          state_next = S_SQR;
        end
      end
      S_SQR: begin
        cmd.op   = OP_SQR;
        cnt_next = cnt + 5'd1;
        if (cnt == SQR_LAST) state_next = S_LOGM;
      end
      S_LOGM: begin
        cmd.op     = OP_LOGM;
        cnt_next   = 5'd0;
        state_next = S_POLY;
      end
      S_POLY: begin
        cmd.op     = OP_POLY;
        cmd.poly_k = cnt[1:0];
        cnt_next   = cnt + 5'd1;
        if (cnt == POLY_LAST) state_next = S_PSHIFT;
      end
      S_PSHIFT: begin
        cmd.op     = OP_PSHIFT;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.op     = OP_GAIN;
        state_next = S_STEP;
      end
      S_STEP: begin
        // wait until the previous result has been taken
        if (!m_tvalid || m_tready) begin
          cmd.op     = OP_STEP;
          out_fire   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= 5'd0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_fire)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign s_tready = (state == S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/core/nsf_dp.sv -----
// Datapath of the nonlinear slew filter: cutoff, divider, log2/exp2 and gain
// with one shared multiplier. Depends on nsf_pkg.
`default_nettype none
module nsf_dp (
  input  wire               clk,
  input  wire               rst,
  input  nsf_pkg::dp_cmd_t  cmd,
  output nsf_pkg::dp_stat_t stat,
  input  wire        [15:0] sample_in,
  input  wire        [15:0] cutoff_mod,
  input  wire        [15:0] base_cutoff,
  input  wire        [15:0] cutoff_depth,
  input  wire        [15:0] steepness,
  output logic       [15:0] sample_out
);
  import nsf_pkg::*;

  logic [15:0] xin, modv, a, held;
  logic        neg, reg1, reg3, yz, ip_big;
  logic [16:0] cu, quot, g, gain;
  logic [17:0] rem, m, t, h;
  logic [4:0]  kneg, ish;
  logic [15:0] frac;

  logic [20:0] mul_a, n;
  logic [17:0] mul_b;
  logic [38:0] prod;

  logic [16:0] d, dneg;
  logic [18:0] c19;
  logic [17:0] two_cu, diff2, sh, ms, addend, tsum, p;
  logic [16:0] num;
  logic        r1, r2, ge;
  logic [36:0] qs;
  logic [24:0] q;
  logic [33:0] gs;
  logic [32:0] ss;
  logic [16:0] sv;
  logic [15:0] svc;

  assign n = {kneg, 16'd0} - {5'd0, frac};

  // shared multiplier operands
  always_comb begin
    unique case (cmd.op)
      OP_CUT:  begin mul_a = {5'd0, ~modv[15], modv[14:0]}; mul_b = {2'd0, cutoff_depth}; end
      OP_SQR:  begin mul_a = {4'd0, m[16:0]};               mul_b = {1'b0, m[16:0]};      end
      OP_LOGM: begin mul_a = n;                             mul_b = {2'd0, steepness};    end
      OP_POLY: begin mul_a = {4'd0, g};                     mul_b = {1'b0, t[16:0]};      end
      OP_GAIN: begin mul_a = {3'd0, h};                     mul_b = {2'd0, GAIN_SCALE};   end
      OP_STEP: begin mul_a = {4'd0, gain};                  mul_b = {2'd0, a};            end
      default: begin mul_a = 21'd0;                         mul_b = 18'd0;                end
    endcase
  end
  assign prod = {18'd0, mul_a} * {21'd0, mul_b};

  always_comb begin
    d      = {xin[15], xin} - {held[15], held};
    dneg   = ~d + 17'd1;
    c19    = {3'd0, base_cutoff} + {2'd0, prod[31:15]} - {3'd0, cutoff_depth};
    two_cu = {cu, 1'b0};
    r1     = ({1'b0, a} <= cu);
    r2     = ({2'd0, a} <= two_cu);
    diff2  = two_cu - {2'd0, a};
    num    = r1 ? {1'b0, a} : diff2[16:0];
    sh     = cmd.first ? rem : {rem[16:0], 1'b0};
    ge     = (sh >= {1'b0, cu});
    ms     = prod[33:16];
    qs     = prod[36:0] + 37'd2048;
    q      = qs[36:12];
    unique case (cmd.poly_k)
      2'd0:    addend = POLY_C2;
      2'd1:    addend = POLY_C1;
      default: addend = ONE_Q16;
    endcase
    tsum = addend + prod[33:16];
    if (yz)          p = (steepness == 16'd0) ? ONE_Q16 : 18'd0;
    else if (ip_big) p = 18'd0;
    else             p = t >> ish;
    gs  = prod[33:0] + 34'd65536;
    ss  = prod[32:0] + 33'd32768;
    sv  = ss[32:16];
    svc = (sv > {1'b0, a}) ? a : sv[15:0];
  end

  assign stat.norm_busy = !m[16] && !yz;
  assign stat.y_zero    = yz;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        xin  <= sample_in;
        modv <= cutoff_mod;
      end
      OP_CUT: begin
        neg <= d[16];
        a   <= d[16] ? dneg[15:0] : d[15:0];
        cu  <= (c19[18] || c19[17:0] == 18'd0) ? 17'd1 : c19[16:0];
      end
      OP_REGION: begin
        reg1 <= r1;
        reg3 <= !r1 && !r2;
        rem  <= {1'b0, num};
        quot <= 17'd0;
      end
      OP_DIV: begin
        rem  <= ge ? sh - {1'b0, cu} : sh;
        quot <= {quot[15:0], ge};
      end
      OP_NINIT: begin
        m    <= {1'b0, quot};
        kneg <= 5'd0;
        yz   <= (quot == 17'd0);
        frac <= 16'd0;
      end
      OP_NORM: begin
        m    <= {m[16:0], 1'b0};
        kneg <= kneg + 5'd1;
      end
      OP_SQR: begin
        frac <= {frac[14:0], ms[17]};
        m    <= ms[17] ? {1'b0, ms[17:1]} : ms;
      end
      OP_LOGM: begin
        ip_big <= (q[24:16] >= 9'd17);
        ish    <= q[20:16] + 5'd1;
        g      <= 17'h10000 - {1'b0, q[15:0]};
        t      <= POLY_C3;
      end
      OP_POLY:   t    <= tsum;
      OP_PSHIFT: h    <= reg1 ? TWO_Q16 - p : p;
      OP_GAIN:   gain <= reg3 ? GAIN_FLOOR : gs[33:17] + GAIN_FLOOR;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 16'd0;
    end else if (cmd.op == OP_STEP) begin
      held <= neg ? held - svc : held + svc;
    end
  end

  assign sample_out = held;

endmodule
`default_nettype wire

// ----- rtl/core/nsf_checker.sv -----
// Port-level checks of the nonlinear slew filter, bound to the top level.
// Depends on nonlinear_slew_filter_macros.svh.
`default_nettype none
`include "nonlinear_slew_filter_macros.svh"
module nsf_sva (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata
);
  `NSF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `NSF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "second item taken while busy")
  `NSF_ASSERT_RST(a_reset_idle, rst, !m_tvalid && s_tready, "not idle after reset")
endmodule

bind nonlinear_slew_filter nsf_sva u_nsf_sva (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
